/* design/hse_pkg.sv */
package hse_pkg;

   // Width of the key ports and of the intermediate sign-extended key.
   localparam int PORT_KEY_W = 32;
   localparam int EXT_W      = 64;

   // Marker bits that travel with each emitted key.
   typedef struct packed {
      logic run_end;
      logic overflowed;
   } hse_tag_type;

endpackage

/* design/heap_sort_engine.sv */
// Heap sort engine: collects a set of signed keys and returns them smallest first.
//
// Input channel (req_): one key word per handshake. req_final_key closes the set.
// Keys past DEPTH are dropped; the set still sorts and every returned word of
// that set carries rsp_overflowed.
// Result channel (rsp_): one word per stored key, ascending, with rsp_run_end
// on the last word of the set.
//
// While loading, req_ready stays high. After the closing key the block accepts no
// input until the last word of the set sits in the output register. The heap
// pass works one sift level at a time on the key store, with two reads and one
// write per sift level, plus steps to start and finish each sift. Draining
// reads each word from the store, then loads it into the output register.
//
// Reset (synchronous, active high) empties the set and the output register;
// the store contents stay undefined and are only read after being written.
// A stalled receiver holds the result word and pauses the drain.
module heap_sort_engine
   import hse_pkg::*;
#(
   parameter int DEPTH     = 64,
   parameter int KEY_WIDTH = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [PORT_KEY_W-1:0] req_key_value,
   input  logic                         req_final_key,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [PORT_KEY_W-1:0] rsp_sorted_key,
   output logic                         rsp_run_end,
   output logic                         rsp_overflowed
);

   logic signed [EXT_W-1:0]     key_ext_in;
   logic signed [KEY_WIDTH-1:0] load_key;
   logic                        emit_valid;
   logic                        emit_ready;
   logic signed [KEY_WIDTH-1:0] emit_key;
   logic signed [EXT_W-1:0]     key_ext_out;
   hse_tag_type                 emit_tag;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [PORT_KEY_W-1:0] rsp_key_ff;
   hse_tag_type                  rsp_tag_ff;

   // Sign-extend the incoming word, then keep the internal key width.
   assign key_ext_in = EXT_W'(req_key_value);
   assign load_key   = key_ext_in[KEY_WIDTH-1:0];

   hse_sequencer #(
      .DEPTH    (DEPTH),
      .KEY_WIDTH(KEY_WIDTH)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .load_valid(req_valid),
      .load_ready(req_ready),
      .load_key  (load_key),
      .load_final(req_final_key),
      .emit_valid(emit_valid),
      .emit_ready(emit_ready),
      .emit_key  (emit_key),
      .emit_tag  (emit_tag)
   );

   // Output register: take a new word when empty or when the current one leaves.
   assign emit_ready   = !rsp_valid_ff || rsp_ready;
   assign key_ext_out  = EXT_W'(emit_key);
   assign rsp_valid_in = (emit_valid && emit_ready) || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (emit_valid && emit_ready) begin
         rsp_key_ff <= key_ext_out[PORT_KEY_W-1:0];
         rsp_tag_ff <= emit_tag;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sorted_key = rsp_key_ff;
   assign rsp_run_end    = rsp_tag_ff.run_end;
   assign rsp_overflowed = rsp_tag_ff.overflowed;

endmodule

/* design/hse_key_ram.sv */
module hse_key_ram
   import hse_pkg::*;
#(
   parameter int DEPTH     = 64,
   parameter int KEY_WIDTH = 32,
   parameter int IDX_W     = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [IDX_W-1:0]     wr_addr,
   input  logic [KEY_WIDTH-1:0] wr_data,
   input  logic                 rd_a_en,
   input  logic [IDX_W-1:0]     rd_a_addr,
   output logic [KEY_WIDTH-1:0] rd_a_data,
   input  logic                 rd_b_en,
   input  logic [IDX_W-1:0]     rd_b_addr,
   output logic [KEY_WIDTH-1:0] rd_b_data
);

   logic [KEY_WIDTH-1:0] mem [DEPTH];
   logic [KEY_WIDTH-1:0] rd_a_ff;
   logic [KEY_WIDTH-1:0] rd_b_ff;

   // Read returns the old contents when the same entry is written in that cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_a_en) begin
         rd_a_ff <= mem[rd_a_addr];
      end
      if (rd_b_en) begin
         rd_b_ff <= mem[rd_b_addr];
      end
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule

/* design/hse_sequencer.sv */
module hse_sequencer
   import hse_pkg::*;
#(
   parameter int DEPTH     = 64,
   parameter int KEY_WIDTH = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        load_valid,
   output logic                        load_ready,
   input  logic signed [KEY_WIDTH-1:0] load_key,
   input  logic                        load_final,
   output logic                        emit_valid,
   input  logic                        emit_ready,
   output logic signed [KEY_WIDTH-1:0] emit_key,
   output hse_tag_type                 emit_tag
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CW    = CNT_W + 1;

   typedef enum logic [3:0] {
      S_LOAD,
      S_BUILD,
      S_HOLD,
      S_EXTRACT,
      S_SWAP,
      S_EVAL,
      S_FINISH,
      S_EMIT_RD,
      S_EMIT_LD
   } state_type;

   state_type                  state_ff, state_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic                       drop_ff, drop_in;
   logic                       extract_ff, extract_in;
   logic [CNT_W-1:0]           outer_ff, outer_in;
   logic [CNT_W-1:0]           limit_ff, limit_in;
   logic [IDX_W-1:0]           sp_ff, sp_in;
   logic signed [KEY_WIDTH-1:0] held_ff, held_in;

   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   logic [KEY_WIDTH-1:0] wr_data;
   logic                 rd_a_en, rd_b_en;
   logic [IDX_W-1:0]     rd_a_addr, rd_b_addr;
   logic [KEY_WIDTH-1:0] rd_a_data, rd_b_data;

   logic signed [KEY_WIDTH-1:0] rd_a_key, rd_b_key, pick_key;
   logic [CW-1:0]    child_a, child_b, pick_idx, next_child, outer_m1;
   logic             pick_b, held_wins, store_full, emit_last;
   logic [CNT_W-1:0] count_inc, n_final;
   state_type        resume_state;

   hse_key_ram #(
      .DEPTH    (DEPTH),
      .KEY_WIDTH(KEY_WIDTH),
      .IDX_W    (IDX_W)
   ) u_ram (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_a_en  (rd_a_en),
      .rd_a_addr(rd_a_addr),
      .rd_a_data(rd_a_data),
      .rd_b_en  (rd_b_en),
      .rd_b_addr(rd_b_addr),
      .rd_b_data(rd_b_data)
   );

   assign rd_a_key = $signed(rd_a_data);
   assign rd_b_key = $signed(rd_b_data);

   // Child selection for one sift level.
   assign child_a    = (CW'(sp_ff) << 1) + CW'(1);
   assign child_b    = child_a + CW'(1);
   assign pick_b     = (child_b < CW'(limit_ff)) && (rd_a_key < rd_b_key);
   assign pick_key   = pick_b ? rd_b_key : rd_a_key;
   assign pick_idx   = pick_b ? child_b : child_a;
   assign held_wins  = !(held_ff < pick_key);
   assign next_child = (pick_idx << 1) + CW'(1);
   assign outer_m1   = CW'(outer_ff) - CW'(1);

   assign store_full   = (count_ff == CNT_W'(DEPTH));
   assign count_inc    = count_ff + CNT_W'(1);
   assign n_final      = store_full ? count_ff : count_inc;
   assign emit_last    = (count_inc == count_ff) ? 1'b0 : ((outer_ff + CNT_W'(1)) == count_ff);
   assign resume_state = extract_ff ? S_EXTRACT : S_BUILD;

   assign load_ready = (state_ff == S_LOAD);
   assign emit_valid = (state_ff == S_EMIT_LD);
   assign emit_key   = rd_a_key;
   assign emit_tag   = '{run_end: emit_last, overflowed: drop_ff};

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      drop_in    = drop_ff;
      extract_in = extract_ff;
      outer_in   = outer_ff;
      limit_in   = limit_ff;
      sp_in      = sp_ff;
      held_in    = held_ff;
      wr_en      = 1'b0;
      wr_addr    = sp_ff;
      wr_data    = held_ff;
      rd_a_en    = 1'b0;
      rd_a_addr  = child_a[IDX_W-1:0];
      rd_b_en    = 1'b0;
      rd_b_addr  = child_b[IDX_W-1:0];

      case (state_ff)
         S_LOAD: begin
            if (load_valid) begin
               if (store_full) begin
                  drop_in = 1'b1;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = count_ff[IDX_W-1:0];
                  wr_data  = load_key;
                  count_in = count_inc;
               end
               if (load_final) begin
                  state_in   = S_BUILD;
                  extract_in = 1'b0;
                  outer_in   = n_final >> 1;
               end
            end
         end
         S_BUILD: begin
            if (outer_ff == '0) begin
               outer_in   = count_ff;
               extract_in = 1'b1;
               state_in   = S_EXTRACT;
            end else begin
               rd_a_en   = 1'b1;
               rd_a_addr = outer_m1[IDX_W-1:0];
               sp_in     = outer_m1[IDX_W-1:0];
               limit_in  = count_ff;
               outer_in  = outer_m1[CNT_W-1:0];
               state_in  = S_HOLD;
            end
         end
         S_HOLD: begin
            held_in = rd_a_key;
            if (child_a < CW'(limit_ff)) begin
               rd_a_en  = 1'b1;
               rd_b_en  = 1'b1;
               state_in = S_EVAL;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_EXTRACT: begin
            if (outer_ff <= CNT_W'(1)) begin
               outer_in = '0;
               state_in = S_EMIT_RD;
            end else begin
               rd_a_en   = 1'b1;
               rd_a_addr = '0;
               rd_b_en   = 1'b1;
               rd_b_addr = outer_m1[IDX_W-1:0];
               state_in  = S_SWAP;
            end
         end
         S_SWAP: begin
            // Old root goes to the end; the displaced key sifts down from the root.
            wr_en     = 1'b1;
            wr_addr   = outer_m1[IDX_W-1:0];
            wr_data   = rd_a_data;
            held_in   = rd_b_key;
            sp_in     = '0;
            limit_in  = outer_m1[CNT_W-1:0];
            outer_in  = outer_m1[CNT_W-1:0];
            rd_a_addr = IDX_W'(1);
            rd_b_addr = IDX_W'(2);
            if (outer_m1 > CW'(1)) begin
               rd_a_en  = 1'b1;
               rd_b_en  = 1'b1;
               state_in = S_EVAL;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_EVAL: begin
            wr_en = 1'b1;
            if (held_wins) begin
               state_in = resume_state;
            end else begin
               wr_data   = pick_key;
               sp_in     = pick_idx[IDX_W-1:0];
               rd_a_addr = next_child[IDX_W-1:0];
               rd_b_addr = IDX_W'(next_child + CW'(1));
               if (next_child < CW'(limit_ff)) begin
                  rd_a_en = 1'b1;
                  rd_b_en = 1'b1;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end
         S_FINISH: begin
            wr_en    = 1'b1;
            state_in = resume_state;
         end
         S_EMIT_RD: begin
            rd_a_en   = 1'b1;
            rd_a_addr = outer_ff[IDX_W-1:0];
            state_in  = S_EMIT_LD;
         end
         S_EMIT_LD: begin
            if (emit_ready) begin
               if (emit_last) begin
                  count_in = '0;
                  drop_in  = 1'b0;
                  outer_in = '0;
                  state_in = S_LOAD;
               end else begin
                  outer_in = outer_ff + CNT_W'(1);
                  state_in = S_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_LOAD;
         count_ff   <= '0;
         drop_ff    <= 1'b0;
         extract_ff <= 1'b0;
         outer_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         drop_ff    <= drop_in;
         extract_ff <= extract_in;
         outer_ff   <= outer_in;
      end
      limit_ff <= limit_in;
      sp_ff    <= sp_in;
      held_ff  <= held_in;
   end

endmodule

/* design/hse_checker.sv */
module hse_checker
   import hse_pkg::*;
(
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         req_final_key,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic signed [PORT_KEY_W-1:0] rsp_sorted_key,
   input logic                         rsp_run_end,
   input logic                         rsp_overflowed
);

   // Hold a stalled result word.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sorted_key)
         && $stable(rsp_run_end) && $stable(rsp_overflowed))
      else $error("stalled result word changed");

   // Close of a set stops loading.
   a_close_blocks: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_final_key |=> !req_ready)
      else $error("input accepted right after closing key");

   // Mid-run words leave no room for new keys.
   a_mid_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_run_end |-> !req_ready)
      else $error("input ready while a set is still draining");

   // Reset empties the output register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind heap_sort_engine hse_checker u_hse_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .req_final_key (req_final_key),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_sorted_key(rsp_sorted_key),
   .rsp_run_end   (rsp_run_end),
   .rsp_overflowed(rsp_overflowed)
);

/* verif/heap_sort_engine_tb.sv */
module heap_sort_engine_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import hse_pkg::*;

   localparam int DEPTH          = 64;
   localparam int CLK_HALF       = 10;
   localparam int RESET_CYCLES   = 4;
   // The slowest quiet stretch in a correct run is the sort of a full store;
   // allow many times that.
   localparam int WATCHDOG_LIMIT = 20000;
   // Cycles to keep watching after the last expected word, to catch strays.
   localparam int TAIL_CYCLES    = 100;

   // One word on the key channel.
   typedef struct {
      logic signed [PORT_KEY_W-1:0] key;
      logic                         last;
   } key_word_type;

   // One word on the sorted channel.
   typedef struct {
      logic signed [PORT_KEY_W-1:0] key;
      hse_tag_type                  tag;
   } sorted_word_type;

   logic                         clock         = 1'b0;
   logic                         reset         = 1'b1;
   logic                         req_valid     = 1'b0;
   logic signed [PORT_KEY_W-1:0] req_key_value = '0;
   logic                         req_final_key = 1'b0;
   logic                         rsp_ready     = 1'b0;
   logic                         req_ready;
   logic                         rsp_valid;
   logic signed [PORT_KEY_W-1:0] rsp_sorted_key;
   logic                         rsp_run_end;
   logic                         rsp_overflowed;

   // Keys waiting to be offered, and words the sorter owes us, oldest first.
   key_word_type    pending_keys[$];
   sorted_word_type sorted_expect[$];

   // Predictor state: the current set kept in ascending order, plus the drop flag.
   logic signed [PORT_KEY_W-1:0] set_keys[$];
   logic                         set_dropped = 1'b0;

   int send_idle_pct   = 11;
   int recv_idle_pct   = 82;
   int queued_count    = 0;
   int accepted_count  = 0;
   int mismatch_count  = 0;
   int words_checked   = 0;
   int sets_sorted     = 0;
   int sets_overflowed = 0;
   int stall_cycles    = 0;

   heap_sort_engine uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_key_value  (req_key_value),
      .req_final_key  (req_final_key),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sorted_key (rsp_sorted_key),
      .rsp_run_end    (rsp_run_end),
      .rsp_overflowed (rsp_overflowed)
   );

   always #(CLK_HALF) clock = ~clock;

   // Count a failure; report only the first few in detail.
   function automatic void flag_error(string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("%0t ns mismatch: %s", $time, msg);
   endfunction

   // Predictor: store the key in sorted position unless the set is full, and on
   // the closing key emit the whole set smallest first. A key arriving at a full
   // store is dropped and taints every word of its set, even when it is the
   // closing key, which still starts the sort.
   function automatic void load_key(key_word_type w);
      int              pos;
      sorted_word_type out;
      pos = 0;
      if (set_keys.size() < DEPTH) begin
         while (pos < set_keys.size() && set_keys[pos] <= w.key) pos++;
         set_keys.insert(pos, w.key);
      end else begin
         set_dropped = 1'b1;
      end
      if (w.last) begin
         for (int k = 0; k < set_keys.size(); k++) begin
            out.key            = set_keys[k];
            out.tag.run_end    = (k == set_keys.size() - 1);
            out.tag.overflowed = set_dropped;
            sorted_expect.push_back(out);
         end
         set_keys.delete();
         set_dropped = 1'b0;
      end
   endfunction

   // Mix the extremes and a narrow band (for duplicates) into full-range keys.
   function automatic logic signed [PORT_KEY_W-1:0] random_key();
      case ($urandom_range(9))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7fff_ffff;
         2, 3:    return $urandom_range(8) - 4;
         default: return $urandom;
      endcase
   endfunction

   task automatic push_key(logic signed [PORT_KEY_W-1:0] k, logic last);
      key_word_type w;
      w.key  = k;
      w.last = last;
      pending_keys.push_back(w);
      queued_count++;
   endtask

   task automatic push_random_set(int n);
      for (int i = 0; i < n; i++) push_key(random_key(), i == n - 1);
   endtask

   // Queue one large set first, then mostly small sets until the budget is used.
   task automatic push_phase(int big_n, int budget);
      int used;
      int n;
      push_random_set(big_n);
      used = big_n;
      while (used < budget) begin
         n = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
         push_random_set(n);
         used += n;
      end
   endtask

   // Hold until every queued key is taken and every owed word has come back.
   task automatic wait_drained();
      while (accepted_count != queued_count || sorted_expect.size() != 0)
         @(posedge clock);
   endtask

   // Driver: feed the predictor on each accepted word, then offer the next key
   // or idle. Valid holds with its payload until the word is taken.
   always @(posedge clock) begin
      key_word_type seen;
      key_word_type next;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            seen.key  = req_key_value;
            seen.last = req_final_key;
            load_key(seen);
            accepted_count++;
         end
         if (!req_valid || req_ready) begin
            if (pending_keys.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next = pending_keys.pop_front();
               req_valid     <= 1'b1;
               req_key_value <= next.key;
               req_final_key <= next.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each accepted sorted word against the oldest expectation,
   // then pick the ready level for the next cycle.
   always @(posedge clock) begin
      sorted_word_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (sorted_expect.size() == 0) begin
               flag_error($sformatf("unexpected word key=%0d run_end=%b overflowed=%b",
                                    rsp_sorted_key, rsp_run_end, rsp_overflowed));
            end else begin
               want = sorted_expect.pop_front();
               words_checked++;
               if (rsp_sorted_key !== want.key || rsp_run_end !== want.tag.run_end ||
                   rsp_overflowed !== want.tag.overflowed)
                  flag_error($sformatf(
                     "expected key=%0d run_end=%b overflowed=%b, got key=%0d run_end=%b overflowed=%b",
                     want.key, want.tag.run_end, want.tag.overflowed,
                     rsp_sorted_key, rsp_run_end, rsp_overflowed));
            end
            if (rsp_run_end === 1'b1) begin
               sets_sorted++;
               if (rsp_overflowed === 1'b1) sets_overflowed++;
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog: any handshake on either side restarts the count of quiet cycles.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t ns: no handshake for %0d cycles, %0d words still owed",
                  $time, WATCHDOG_LIMIT, sorted_expect.size());
         $display("FAIL");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed sets, run with a slow receiver.
      // Single-key sets at both extremes.
      push_key(32'sh8000_0000, 1'b1);
      push_key(32'sh7fff_ffff, 1'b1);
      // Extremes and values around zero in one set.
      push_key(32'sh7fff_ffff, 1'b0);
      push_key(32'sh8000_0000, 1'b0);
      push_key(32'sh0000_0000, 1'b0);
      push_key(-32'sd1, 1'b0);
      push_key(32'sd1, 1'b1);
      // Equal keys land next to each other.
      push_key(32'sd7, 1'b0);
      push_key(32'sd7, 1'b0);
      push_key(-32'sd3, 1'b0);
      push_key(32'sd7, 1'b0);
      push_key(-32'sd3, 1'b1);
      // Alternating bit patterns.
      push_key(32'sh5555_5555, 1'b0);
      push_key(32'shAAAA_AAAA, 1'b1);
      // Already descending input, which the build pass finds already in heap order.
      push_key(32'sd4, 1'b0);
      push_key(32'sd3, 1'b0);
      push_key(32'sd2, 1'b0);
      push_key(32'sd1, 1'b1);

      // Slow receiver: a set one past capacity drops its closing key.
      push_phase(DEPTH + 1, 110);
      wait_drained();

      // Slow sender: a set that exactly fills the store must not overflow.
      send_idle_pct = 82;
      recv_idle_pct = 11;
      push_phase(DEPTH, 115);
      wait_drained();

      // Full rate both ways: drop several keys, then check the flag clears.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      push_phase(DEPTH + 3, 115);
      wait_drained();

      // Watch for stray words after the last expected one.
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Loaded %0d keys and checked %0d sorted words in %0d sets.",
               accepted_count, words_checked, sets_sorted);
      $display("%0d sets overflowed the %0d-entry store; %0d mismatches.",
               sets_overflowed, DEPTH, mismatch_count);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

/* sim.f */
design/hse_pkg.sv
design/hse_key_ram.sv
design/hse_sequencer.sv
design/heap_sort_engine.sv
design/hse_checker.sv
verif/heap_sort_engine_tb.sv
